### design/aiosc_pkg.sv
// ----------------------------------------------------------------------------
// aiosc_pkg: shared types and constants of the aux I/O / system-control block
// Operation and register codes, bit positions and the beat structures.
// ----------------------------------------------------------------------------
`default_nettype none

package aiosc_pkg;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PFAIL = 2'd2;

    // register select codes
    localparam logic [2:0] RG_CONTROL = 3'd0;
    localparam logic [2:0] RG_DIAG    = 3'd1;
    localparam logic [2:0] RG_MODEM   = 3'd2;
    localparam logic [2:0] RG_AUX1    = 3'd3;
    localparam logic [2:0] RG_AUX2    = 3'd4;
    localparam logic [2:0] RG_LEDS    = 3'd5;
    localparam logic [2:0] RG_SYSCTRL = 3'd6;

    // bit positions
    localparam int AUX1_TC_BIT     = 1;    // 0x02
    localparam int AUX2_PWROFF_BIT = 0;    // 0x01
    localparam int AUX2_INTCLR_BIT = 1;    // 0x02
    localparam int AUX2_PFAIL_BIT  = 5;    // 0x20
    localparam int CTL_PWRINTEN    = 3;    // 0x08
    localparam int SYS_RESET_BIT   = 0;    // 0x01
    localparam int SYS_RSTSTAT_BIT = 1;    // 0x02

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  region;
        logic [1:0]  offset;
        logic [31:0] write_data;
        logic        pfail_level;
    } t_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_level;
        logic        tc_pulse;
        logic        shutdown_request;
        logic        reset_request;
    } t_result;

endpackage

`default_nettype wire

### design/aiosc_if.sv
// ----------------------------------------------------------------------------
// aiosc_in_if / aiosc_out_if: valid/ready channels of the block
// Request channel carries one access or power-fail event per beat; response
// channel carries one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface aiosc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  region;
    logic [1:0]  offset;
    logic [31:0] write_data;
    logic        pfail_level;

    modport source (output valid, output op, output region, output offset,
                    output write_data, output pfail_level, input ready);
    modport sink   (input valid, input op, input region, input offset,
                    input write_data, input pfail_level, output ready);
endinterface

interface aiosc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_data;
    logic        irq_level;
    logic        tc_pulse;
    logic        shutdown_request;
    logic        reset_request;

    modport source (output valid, output read_data, output irq_level,
                    output tc_pulse, output shutdown_request,
                    output reset_request, input ready);
    modport sink   (input valid, input read_data, input irq_level,
                    input tc_pulse, input shutdown_request,
                    input reset_request, output ready);
endinterface

`default_nettype wire

### design/aiosc_regs.sv
// ----------------------------------------------------------------------------
// aiosc_regs: register file and access decode
// Holds the control, diag, modem, aux and LED registers, applies one beat
// per accepted cycle and forms its result from the state around that beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aiosc_regs
    import aiosc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire t_item   i_item,
    output t_result      o_result
);

    logic [7:0]  r_control, n_control;
    logic [7:0]  r_diag,    n_diag;
    logic [7:0]  r_modem,   n_modem;
    logic [7:0]  r_aux1,    n_aux1;
    // aux2 only ever holds the power-off and power-fail bits
    logic        r_pwroff,  n_pwroff;
    logic        r_pwrfail, n_pwrfail;
    logic        r_rststat, n_rststat;
    logic [15:0] r_leds,    n_leds;

    logic [7:0]  aux2_view;
    logic [7:0]  sys_view;
    logic [15:0] rd;
    logic        tc, sd, rr;

    assign aux2_view = {2'b00, r_pwrfail, 4'b0000, r_pwroff};
    assign sys_view  = {6'b000000, r_rststat, 1'b0};

    always_comb begin
        n_control = r_control;
        n_diag    = r_diag;
        n_modem   = r_modem;
        n_aux1    = r_aux1;
        n_pwroff  = r_pwroff;
        n_pwrfail = r_pwrfail;
        n_rststat = r_rststat;
        n_leds    = r_leds;
        rd        = '0;
        tc        = 1'b0;
        sd        = 1'b0;
        rr        = 1'b0;
        unique case (i_item.op)
            OP_READ: begin
                unique case (i_item.region)
                    RG_CONTROL: rd = {8'h00, r_control};
                    RG_DIAG:    rd = {8'h00, r_diag};
                    RG_MODEM:   rd = {8'h00, r_modem};
                    RG_AUX1:    rd = {8'h00, r_aux1};
                    RG_AUX2:    rd = {8'h00, aux2_view};
                    RG_LEDS:    rd = (i_item.offset == 2'd0) ? r_leds : '0;
                    RG_SYSCTRL: rd = (i_item.offset == 2'd0) ? {8'h00, sys_view} : '0;
                    default:    rd = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_item.region)
                    RG_CONTROL: n_control = i_item.write_data[7:0];
                    RG_DIAG:    n_diag    = i_item.write_data[7:0];
                    RG_MODEM:   n_modem   = i_item.write_data[7:0];
                    RG_AUX1: begin
                        // terminal count bit pulses and is never stored
                        tc     = i_item.write_data[AUX1_TC_BIT];
                        n_aux1 = i_item.write_data[7:0] & ~(8'h01 << AUX1_TC_BIT);
                    end
                    RG_AUX2: begin
                        n_pwroff = i_item.write_data[AUX2_PWROFF_BIT];
                        if (i_item.write_data[AUX2_INTCLR_BIT]) begin
                            n_pwrfail = 1'b0;
                        end
                        sd = i_item.write_data[AUX2_PWROFF_BIT];
                    end
                    RG_LEDS: begin
                        if (i_item.offset == 2'd0) begin
                            n_leds = i_item.write_data[15:0];
                        end
                    end
                    RG_SYSCTRL: begin
                        if (i_item.offset == 2'd0 && i_item.write_data[SYS_RESET_BIT]) begin
                            n_rststat = 1'b1;
                            rr        = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_PFAIL: n_pwrfail = i_item.pfail_level & r_control[CTL_PWRINTEN];
            default: ;
        endcase
    end

    assign o_result.read_data        = rd;
    assign o_result.irq_level        = n_pwrfail & n_control[CTL_PWRINTEN];
    assign o_result.tc_pulse         = tc;
    assign o_result.shutdown_request = sd;
    assign o_result.reset_request    = rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_diag    <= '0;
            r_modem   <= '0;
            r_aux1    <= '0;
            r_pwroff  <= 1'b0;
            r_pwrfail <= 1'b0;
            r_rststat <= 1'b0;
            r_leds    <= '0;
        end else if (i_accept) begin
            r_control <= n_control;
            r_diag    <= n_diag;
            r_modem   <= n_modem;
            r_aux1    <= n_aux1;
            r_pwroff  <= n_pwroff;
            r_pwrfail <= n_pwrfail;
            r_rststat <= n_rststat;
            r_leds    <= n_leds;
        end
    end

`ifndef SYNTH
    a_aux1_tc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_aux1[AUX1_TC_BIT])
        else $error("aux1 terminal count bit stored");

    a_pfail_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.op == OP_PFAIL && !i_item.pfail_level |=> !r_pwrfail)
        else $error("power-fail bit kept after line went good");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.op != OP_READ |-> o_result.read_data == 16'h0000)
        else $error("read data on a non-read beat");
`endif

endmodule

`default_nettype wire

### design/aux_io_system_control_regs.sv
// ----------------------------------------------------------------------------
// aux_io_system_control_regs: auxiliary I/O and system-control registers
// Top level: request/response channels around the register file, with an
// output register and a skid stage on the response side.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one beat per bus read, bus write or power-fail line event.
//   o_rsp returns exactly one beat per request: read data (zero for
//   non-reads), the power-fail interrupt level after the request, and
//   single-beat terminal count, shutdown and reset request flags.
//   Response: each result is registered in the output register, or in
//   the skid stage while that is held. Throughput: one request per cycle
//   while i_req.ready is high; back-to-back accesses to the same register
//   see each other's effect, as each accepted request updates the file.
//   Stall: when o_rsp.ready is low the response holds in the output
//   register and one more request is taken into the skid stage; i_req.ready
//   drops only while the skid stage is full.
//   Reset (synchronous, active low): all registers, the LED word and the
//   reset status clear to zero and both response stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module aux_io_system_control_regs
    import aiosc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    aiosc_in_if.sink     i_req,
    aiosc_out_if.source  o_rsp
);

    t_item   item;
    t_result result;
    logic    accept;
    logic    pop;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skid;
    logic    r_skid_valid;

    assign item.op          = i_req.op;
    assign item.region      = i_req.region;
    assign item.offset      = i_req.offset;
    assign item.write_data  = i_req.write_data;
    assign item.pfail_level = i_req.pfail_level;

    assign i_req.ready = !r_skid_valid;
    assign accept      = i_req.valid && !r_skid_valid;
    assign pop         = r_out_valid && o_rsp.ready;

    aiosc_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (r_skid_valid) begin
                    // advance the skid beat; no accept while it is full
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= accept;
                    r_out       <= result;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= accept;
                r_out       <= result;
            end else if (accept) begin
                // hold the output beat, park the new one
                r_skid       <= result;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.read_data        = r_out.read_data;
    assign o_rsp.irq_level        = r_out.irq_level;
    assign o_rsp.tc_pulse         = r_out.tc_pulse;
    assign o_rsp.shutdown_request = r_out.shutdown_request;
    assign o_rsp.reset_request    = r_out.reset_request;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full with output register empty");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted request produced no response");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && o_rsp.ready |=> !r_skid_valid)
        else $error("skid stage did not drain on pop");
`endif

endmodule

`default_nettype wire
